// ===== rtl/pdc_pkg.sv =====
// Shared types and constants for the four-channel PID drive core.
package pdc_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int ERR_W    = 16;
    localparam int DELTA_W  = 24;
    localparam int INTEG_W  = 32;
    localparam int LIMIT_W  = 31;
    localparam int DRIVE_W  = 8;

    // shared multiplier: 17-bit signed coefficient times 33-bit signed operand
    localparam int MUL_A_W  = 17;
    localparam int MUL_B_W  = 33;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 8'sd120;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -8'sd120;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RATE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 3'd5;
    localparam int CFG_DATA_W = 31;

    localparam logic [15:0]        INV_RATE_RST  = 16'd655;
    localparam logic [LIMIT_W-1:0] INT_LIMIT_RST = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [15:0]        gain_p;
        logic signed [15:0]        gain_i;
        logic signed [15:0]        gain_d;
        logic [7:0]                momentum;
        logic [15:0]               inv_rate;
        logic [LIMIT_W-1:0]        integral_limit;
    } t_cfg;

    // one word of per-channel loop state
    typedef struct packed {
        logic signed [ERR_W-1:0]   last_error;
        logic signed [DELTA_W-1:0] delta;
        logic signed [INTEG_W-1:0] integral;
    } t_state_word;

endpackage

// ===== rtl/four_channel_pid_drive_core.sv =====
// Top level of the four-channel PID drive core: control, state memory, output register.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------
//  input    | in        | i_in_valid / o_in_stall    | i_operation, i_error_0..i_error_3
//  result   | out       | o_out_valid / i_out_stall  | o_drive_0..o_drive_3
//  config   | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_wdata
//
// A control item runs each channel as five products in a row on the single multiplier
// in pdc_chan_unit, plus result conversion. A priming item makes one state write per
// channel; a clear only stops the loop and writes no state. Reset is synchronous and
// needs no memory sweep. One item is worked at a time; a finished result waits in the
// output register under stall while the next item is accepted and worked.
module four_channel_pid_drive_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_operation,
    input  logic signed [pdc_pkg::ERR_W-1:0]   i_error_0,
    input  logic signed [pdc_pkg::ERR_W-1:0]   i_error_1,
    input  logic signed [pdc_pkg::ERR_W-1:0]   i_error_2,
    input  logic signed [pdc_pkg::ERR_W-1:0]   i_error_3,

    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [pdc_pkg::DRIVE_W-1:0] o_drive_0,
    output logic signed [pdc_pkg::DRIVE_W-1:0] o_drive_1,
    output logic signed [pdc_pkg::DRIVE_W-1:0] o_drive_2,
    output logic signed [pdc_pkg::DRIVE_W-1:0] o_drive_3,

    input  logic                               i_cfg_we,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PRIME = 4'b0010,
        ST_CALC  = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_top_state;

    t_top_state r_state, n_state;

    logic [pdc_pkg::CH_W-1:0] r_ch, n_ch;
    logic                     r_running, n_running;
    logic                     r_start, n_start;
    logic                     r_out_valid;
    pdc_pkg::t_cfg            r_cfg;

    logic signed [pdc_pkg::ERR_W-1:0]   r_err [pdc_pkg::CHANNELS];
    logic signed [pdc_pkg::DRIVE_W-1:0] r_res [pdc_pkg::CHANNELS];
    logic signed [pdc_pkg::DRIVE_W-1:0] r_out [pdc_pkg::CHANNELS];

    // per-channel loop state
    pdc_pkg::t_state_word r_mem [pdc_pkg::CHANNELS];
    pdc_pkg::t_state_word r_rdata;
    pdc_pkg::t_state_word mem_wdata;
    logic                 mem_we;

    logic                                in_acc;
    logic                                out_free;
    logic                                last_ch;
    logic                                u_done;
    logic signed [pdc_pkg::DRIVE_W-1:0]  u_drive;
    pdc_pkg::t_state_word                u_state;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign last_ch    = (r_ch == pdc_pkg::CH_W'(pdc_pkg::CHANNELS - 1));

    always_comb begin
        n_state   = r_state;
        n_ch      = r_ch;
        n_running = r_running;
        n_start   = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = u_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_operation) begin
                        n_running = 1'b0;
                    end else if (!r_running) begin
                        n_state = ST_PRIME;
                        n_ch    = '0;
                    end else begin
                        n_state = ST_CALC;
                        n_ch    = '0;
                        n_start = 1'b1;
                    end
                end
            end
            ST_PRIME: begin
                mem_we               = 1'b1;
                mem_wdata.last_error = r_err[r_ch];
                mem_wdata.delta      = '0;
                mem_wdata.integral   = '0;
                if (last_ch) begin
                    n_running = 1'b1;
                    n_state   = ST_IDLE;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            ST_CALC: begin
                if (u_done) begin
                    mem_we = 1'b1;
                    if (last_ch) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_start = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= '0;
            r_running   <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ch      <= n_ch;
            r_running <= n_running;
            r_start   <= n_start;
            if (r_state == ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.momentum       <= '0;
            r_cfg.inv_rate       <= pdc_pkg::INV_RATE_RST;
            r_cfg.integral_limit <= pdc_pkg::INT_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pdc_pkg::CFG_GAIN_P:    r_cfg.gain_p         <= i_cfg_wdata[15:0];
                pdc_pkg::CFG_GAIN_I:    r_cfg.gain_i         <= i_cfg_wdata[15:0];
                pdc_pkg::CFG_GAIN_D:    r_cfg.gain_d         <= i_cfg_wdata[15:0];
                pdc_pkg::CFG_MOMENTUM:  r_cfg.momentum       <= i_cfg_wdata[7:0];
                pdc_pkg::CFG_INV_RATE:  r_cfg.inv_rate       <= i_cfg_wdata[15:0];
                pdc_pkg::CFG_INT_LIMIT: r_cfg.integral_limit <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // item capture, per-channel results, output register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_err[0] <= i_error_0;
            r_err[1] <= i_error_1;
            r_err[2] <= i_error_2;
            r_err[3] <= i_error_3;
        end
        if (r_state == ST_CALC && u_done) begin
            r_res[r_ch] <= u_drive;
        end
        if (r_state == ST_EMIT && out_free) begin
            r_out <= r_res;
        end
    end

    // state memory: read address is the channel of the coming cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_ch] <= mem_wdata;
        end
        r_rdata <= r_mem[n_ch];
    end

    pdc_chan_unit u_chan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_cfg   (r_cfg),
        .i_error (r_err[r_ch]),
        .i_state (r_rdata),
        .o_done  (u_done),
        .o_drive (u_drive),
        .o_state (u_state)
    );

    assign o_out_valid = r_out_valid;
    assign o_drive_0   = r_out[0];
    assign o_drive_1   = r_out[1];
    assign o_drive_2   = r_out[2];
    assign o_drive_3   = r_out[3];

endmodule

// ===== rtl/pdc_chan_unit.sv =====
// Per-channel PID update on one shared multiplier, one product per cycle.
module pdc_chan_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  pdc_pkg::t_cfg                         i_cfg,
    input  logic signed [pdc_pkg::ERR_W-1:0]      i_error,
    input  pdc_pkg::t_state_word                  i_state,
    output logic                                  o_done,
    output logic signed [pdc_pkg::DRIVE_W-1:0]    o_drive,
    output pdc_pkg::t_state_word                  o_state
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DER  = 7'b0000010,
        S_INT  = 7'b0000100,
        S_DMUL = 7'b0001000,
        S_IMUL = 7'b0010000,
        S_ACC  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_step;

    t_step r_step, n_step;

    logic signed [pdc_pkg::ERR_W-1:0]   r_e, r_last;
    logic signed [pdc_pkg::DELTA_W-1:0] r_d;
    logic signed [pdc_pkg::INTEG_W-1:0] r_i;
    logic signed [pdc_pkg::PROD_W-1:0]  r_prod;
    logic signed [pdc_pkg::PROD_W-1:0]  r_acc;

    logic signed [pdc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pdc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [pdc_pkg::PROD_W-1:0]  mul_p;

    logic signed [16:0]                 diff;
    logic signed [24:0]                 mom_term;
    logic signed [25:0]                 dsum;
    logic signed [pdc_pkg::DELTA_W-1:0] d_new;

    logic signed [16:0]                 inc;
    logic signed [33:0]                 isum;
    logic signed [33:0]                 lim_pos;
    logic signed [33:0]                 lim_neg;
    logic signed [pdc_pkg::INTEG_W-1:0] i_new;

    logic signed [33:0]                 quot;
    logic signed [33:0]                 quot_t;

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_step)
            S_IDLE: begin
                mul_a = $signed({9'b0, i_cfg.momentum});
                mul_b = 33'(i_state.delta);
            end
            S_DER: begin
                mul_a = $signed({1'b0, i_cfg.inv_rate});
                mul_b = 33'(r_e);
            end
            S_INT: begin
                mul_a = 17'(i_cfg.gain_p);
                mul_b = 33'(r_e);
            end
            S_DMUL: begin
                mul_a = 17'(i_cfg.gain_d);
                mul_b = 33'(r_d);
            end
            S_IMUL: begin
                mul_a = 17'(i_cfg.gain_i);
                mul_b = 33'(r_i);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // smoothed derivative: floor(momentum*old/256) is an arithmetic shift
    always_comb begin
        diff     = 17'(r_e) - 17'(r_last);
        mom_term = r_prod[32:8];
        dsum     = 26'(diff) + 26'(mom_term);
        if (dsum[25:23] == 3'b000 || dsum[25:23] == 3'b111) begin
            d_new = dsum[23:0];
        end else if (dsum[25]) begin
            d_new = {1'b1, {(pdc_pkg::DELTA_W-1){1'b0}}};
        end else begin
            d_new = {1'b0, {(pdc_pkg::DELTA_W-1){1'b1}}};
        end
    end

    // integral with symmetric windup clamp
    always_comb begin
        inc     = r_prod[32:16];
        isum    = 34'(r_i) + 34'(inc);
        lim_pos = $signed({3'b000, i_cfg.integral_limit});
        lim_neg = -lim_pos;
        if (isum > lim_pos) begin
            i_new = lim_pos[31:0];
        end else if (isum < lim_neg) begin
            i_new = lim_neg[31:0];
        end else begin
            i_new = isum[31:0];
        end
    end

    // Q.16 accumulator to integer, truncated toward zero, then clipped
    always_comb begin
        quot   = r_acc[pdc_pkg::PROD_W-1:16];
        quot_t = quot + 34'(r_acc[pdc_pkg::PROD_W-1] && (r_acc[15:0] != 16'd0));
        if (quot_t > 34'(pdc_pkg::DRIVE_MAX)) begin
            o_drive = pdc_pkg::DRIVE_MAX;
        end else if (quot_t < 34'(pdc_pkg::DRIVE_MIN)) begin
            o_drive = pdc_pkg::DRIVE_MIN;
        end else begin
            o_drive = quot_t[pdc_pkg::DRIVE_W-1:0];
        end
    end

    always_comb begin
        n_step = r_step;
        unique case (r_step)
            S_IDLE:  if (i_start) n_step = S_DER;
            S_DER:   n_step = S_INT;
            S_INT:   n_step = S_DMUL;
            S_DMUL:  n_step = S_IMUL;
            S_IMUL:  n_step = S_ACC;
            S_ACC:   n_step = S_OUT;
            S_OUT:   n_step = S_IDLE;
            default: n_step = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_step)
            S_IDLE: begin
                if (i_start) begin
                    r_e    <= i_error;
                    r_last <= i_state.last_error;
                    r_d    <= i_state.delta;
                    r_i    <= i_state.integral;
                    r_prod <= mul_p;
                end
            end
            S_DER: begin
                r_d    <= d_new;
                r_prod <= mul_p;
            end
            S_INT: begin
                r_i    <= i_new;
                r_prod <= mul_p;
            end
            S_DMUL: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            S_IMUL: begin
                r_acc  <= r_acc + r_prod;
                r_prod <= mul_p;
            end
            S_ACC: begin
                r_acc  <= r_acc + r_prod;
            end
            default: begin
            end
        endcase
    end

    assign o_done             = (r_step == S_OUT);
    assign o_state.last_error = r_e;
    assign o_state.delta      = r_d;
    assign o_state.integral   = r_i;

endmodule

// ===== dv/tb_four_channel_pid_drive_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for four_channel_pid_drive_core: drives items, predicts and checks drives.
module tb_four_channel_pid_drive_core;
    import pdc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_PRINTED   = 50;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [ERR_W-1:0] ERR_MAX = 16'h7FFF;
    localparam logic [ERR_W-1:0] ERR_MIN = 16'h8000;

    localparam longint DELTA_MAX = (64'sd1 <<< (DELTA_W - 1)) - 64'sd1;
    localparam longint DELTA_MIN = -(64'sd1 <<< (DELTA_W - 1));

    typedef enum bit {OP_SAMPLE = 1'b0, OP_CLEAR = 1'b1} op_t;
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef logic [CHANNELS-1:0][ERR_W-1:0]   err_vec_t;
    typedef logic [CHANNELS-1:0][DRIVE_W-1:0] drive_vec_t;

    class pid_drive_scoreboard;
        t_cfg                      regs;
        bit                        running;
        logic signed [ERR_W-1:0]   past_err [CHANNELS];
        logic signed [DELTA_W-1:0] delta    [CHANNELS];
        logic signed [INTEG_W-1:0] integ    [CHANNELS];
        drive_vec_t                drive_due [$];
        int                        fail_count;

        function new();
            regs.gain_p         = '0;
            regs.gain_i         = '0;
            regs.gain_d         = '0;
            regs.momentum       = '0;
            regs.inv_rate       = INV_RATE_RST;
            regs.integral_limit = INT_LIMIT_RST;
            running    = 1'b0;
            fail_count = 0;
            foreach (past_err[c]) begin
                past_err[c] = '0;
                delta[c]    = '0;
                integ[c]    = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GAIN_P:    regs.gain_p         = data[15:0];
                CFG_GAIN_I:    regs.gain_i         = data[15:0];
                CFG_GAIN_D:    regs.gain_d         = data[15:0];
                CFG_MOMENTUM:  regs.momentum       = data[7:0];
                CFG_INV_RATE:  regs.inv_rate       = data[15:0];
                CFG_INT_LIMIT: regs.integral_limit = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return drive_due.size();
        endfunction

        // works out the drives an accepted item causes, if any
        function void note_item(op_t op, err_vec_t err);
            longint     e, d, i, acc, drv, lim;
            drive_vec_t res;
            int         c;
            if (op == OP_CLEAR) begin
                running = 1'b0;
                return;
            end
            if (!running) begin
                running = 1'b1;
                for (c = 0; c < CHANNELS; c++) begin
                    past_err[c] = err[c];
                    delta[c]    = '0;
                    integ[c]    = '0;
                end
                return;
            end
            lim = longint'(regs.integral_limit);
            for (c = 0; c < CHANNELS; c++) begin
                e = longint'($signed(err[c]));
                // >>> on a signed product gives the floor
                d = e - longint'(past_err[c])
                    + ((longint'(regs.momentum) * longint'(delta[c])) >>> 8);
                if (d > DELTA_MAX) d = DELTA_MAX;
                if (d < DELTA_MIN) d = DELTA_MIN;

                i = longint'(integ[c]) + ((e * longint'(regs.inv_rate)) >>> 16);
                if (i > lim) i = lim;
                if (i < -lim) i = -lim;

                acc = longint'($signed(regs.gain_p)) * e
                    + longint'($signed(regs.gain_d)) * d
                    + longint'($signed(regs.gain_i)) * i;
                drv = acc / 64'sd65536;   // truncates toward zero
                if (drv > longint'(DRIVE_MAX)) drv = longint'(DRIVE_MAX);
                if (drv < longint'(DRIVE_MIN)) drv = longint'(DRIVE_MIN);

                delta[c]    = d[DELTA_W-1:0];
                integ[c]    = i[INTEG_W-1:0];
                past_err[c] = err[c];
                res[c]      = drv[DRIVE_W-1:0];
            end
            drive_due.push_back(res);
        endfunction

        task report(string msg);
            if (fail_count < MAX_PRINTED) $display("%0t ERROR: %s", $time, msg);
            fail_count++;
        endtask

        task check_result(drive_vec_t got);
            drive_vec_t want;
            int         c;
            if (drive_due.size() == 0) begin
                report("drive result with no item pending");
                return;
            end
            want = drive_due.pop_front();
            for (c = 0; c < CHANNELS; c++) begin
                if (got[c] !== want[c])
                    report($sformatf("drive_%0d got %0d want %0d", c,
                                     $signed(got[c]), $signed(want[c])));
            end
        endtask
    endclass

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    logic                      i_operation = 1'b0;
    logic signed [ERR_W-1:0]   i_error_0   = '0;
    logic signed [ERR_W-1:0]   i_error_1   = '0;
    logic signed [ERR_W-1:0]   i_error_2   = '0;
    logic signed [ERR_W-1:0]   i_error_3   = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [DRIVE_W-1:0] o_drive_0;
    logic signed [DRIVE_W-1:0] o_drive_1;
    logic signed [DRIVE_W-1:0] o_drive_2;
    logic signed [DRIVE_W-1:0] o_drive_3;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_wdata = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    pid_drive_scoreboard sb;

    four_channel_pid_drive_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_error_0   (i_error_0),
        .i_error_1   (i_error_1),
        .i_error_2   (i_error_2),
        .i_error_3   (i_error_3),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_drive_0   (o_drive_0),
        .o_drive_1   (o_drive_1),
        .o_drive_2   (o_drive_2),
        .o_drive_3   (o_drive_3),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_drive_3, o_drive_2, o_drive_1, o_drive_0});
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL four_channel_pid_drive_core");
            $finish;
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct  = 56;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 56;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 19;
                recv_stall_pct = 19;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // returns at the edge where the item is taken; valid stays up for a back-to-back item
    task automatic send_item(input op_t op,
                             input logic [ERR_W-1:0] e0, e1, e2, e3);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_error_0   <= e0;
        i_error_1   <= e1;
        i_error_2   <= e2;
        i_error_3   <= e3;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(op, {e3, e2, e1, e0});
    endtask

    // lets the block go idle: all results out, then priming or a clear may still be running
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic apply_cfg(input t_cfg c);
        put_reg(CFG_GAIN_P,    {15'd0, c.gain_p});
        put_reg(CFG_GAIN_I,    {15'd0, c.gain_i});
        put_reg(CFG_GAIN_D,    {15'd0, c.gain_d});
        put_reg(CFG_MOMENTUM,  {23'd0, c.momentum});
        put_reg(CFG_INV_RATE,  {15'd0, c.inv_rate});
        put_reg(CFG_INT_LIMIT, c.integral_limit);
        // unmapped index, must leave every register alone
        put_reg(($urandom_range(1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_cfg make_cfg(input logic [15:0] gp, gi, gd,
                                      input logic [7:0] mom, input logic [15:0] rate,
                                      input logic [LIMIT_W-1:0] lim);
        t_cfg c;
        c.gain_p         = gp;
        c.gain_i         = gi;
        c.gain_d         = gd;
        c.momentum       = mom;
        c.inv_rate       = rate;
        c.integral_limit = lim;
        return c;
    endfunction

    function automatic logic [15:0] rand_gain();
        if ($urandom_range(1) != 0)
            return 16'($urandom);
        return 16'($urandom_range(2048) - 1024);
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.gain_p   = rand_gain();
        c.gain_i   = rand_gain();
        c.gain_d   = rand_gain();
        c.momentum = 8'($urandom);
        c.inv_rate = ($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(2000));
        case ($urandom_range(3))
            0:       c.integral_limit = LIMIT_W'($urandom);
            1:       c.integral_limit = LIMIT_W'($urandom_range(400000));
            2:       c.integral_limit = LIMIT_W'($urandom_range(4000));
            default: c.integral_limit = INT_LIMIT_RST;
        endcase
        return c;
    endfunction

    // mostly small errors so drives do not always sit at the clip
    function automatic logic [ERR_W-1:0] rand_err();
        logic [ERR_W-1:0] v;
        case ($urandom_range(7))
            0, 1: v = 16'($urandom);
            2: begin
                case ($urandom_range(3))
                    0:       v = ERR_MAX;
                    1:       v = ERR_MIN;
                    2:       v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
            default: v = 16'($urandom_range(3000) - 1500);
        endcase
        return v;
    endfunction

    initial begin
        t_cfg c;
        int   ph;
        int   n;
        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register reset values: all gains zero
        send_item(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_SAMPLE, ERR_MAX, ERR_MIN, ERR_MAX, ERR_MIN);
        send_item(OP_SAMPLE, ERR_MIN, ERR_MAX, 16'h0000, 16'hFFFF);
        drain();

        apply_cfg(make_cfg(16'd256, 16'd512, 16'd128, 8'd128, 16'hFFFF, 31'd3000));
        // clear while running, then clear while already stopped
        send_item(OP_CLEAR, rand_err(), rand_err(), rand_err(), rand_err());
        send_item(OP_CLEAR, rand_err(), rand_err(), rand_err(), rand_err());
        send_item(OP_SAMPLE, 16'h0100, 16'hFF00, ERR_MAX, ERR_MIN);
        send_item(OP_SAMPLE, ERR_MAX, ERR_MIN, ERR_MIN, ERR_MAX);
        send_item(OP_SAMPLE, ERR_MAX, ERR_MAX, ERR_MAX, ERR_MAX);
        send_item(OP_SAMPLE, ERR_MAX, ERR_MAX, ERR_MAX, ERR_MAX);
        send_item(OP_SAMPLE, ERR_MIN, ERR_MIN, ERR_MIN, ERR_MIN);
        send_item(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_SAMPLE, 16'h0100, 16'hFF00, 16'h0200, 16'hFE00);
        send_item(OP_CLEAR, rand_err(), rand_err(), rand_err(), rand_err());
        send_item(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_SAMPLE, 16'h0001, 16'hFFFF, 16'h0002, 16'hFFFE);
        drain();

        // extreme gains, full momentum, zero integral limit
        apply_cfg(make_cfg(16'h8000, 16'h7FFF, 16'h8000, 8'hFF, 16'hFFFF, 31'd0));
        send_item(OP_CLEAR, rand_err(), rand_err(), rand_err(), rand_err());
        send_item(OP_SAMPLE, ERR_MIN, ERR_MAX, ERR_MIN, ERR_MAX);
        send_item(OP_SAMPLE, ERR_MAX, ERR_MIN, ERR_MAX, ERR_MIN);
        send_item(OP_SAMPLE, ERR_MIN, ERR_MAX, ERR_MIN, ERR_MAX);
        send_item(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drain();

        // other extremes, state carried over from the last phase
        apply_cfg(make_cfg(16'h7FFF, 16'h8000, 16'h7FFF, 8'h00, 16'h0000, INT_LIMIT_RST));
        send_item(OP_SAMPLE, ERR_MAX, ERR_MAX, ERR_MIN, ERR_MIN);
        send_item(OP_SAMPLE, ERR_MIN, ERR_MIN, ERR_MAX, ERR_MAX);
        send_item(OP_SAMPLE, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            c = rand_cfg();
            if (ph == 0) begin
                c.momentum       = 8'h00;
                c.inv_rate       = 16'hFFFF;
                c.integral_limit = INT_LIMIT_RST;
            end
            apply_cfg(c);
            set_idle(idle_mode_t'(ph % 4));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_item(($urandom_range(24) == 0) ? OP_CLEAR : OP_SAMPLE,
                          rand_err(), rand_err(), rand_err(), rand_err());
            end
        end
        drain();

        if (sb.fail_count == 0) begin
            $display("PASS four_channel_pid_drive_core");
        end else begin
            $display("FAIL four_channel_pid_drive_core");
        end
        $finish;
    end

endmodule
